FILE: rtl/cab_pkg.sv
// Shared types and constants for the CIGAR to alignment block converter.
`timescale 1ns / 1ps
`default_nettype none

package cab_pkg;

	localparam int DEF_POSITION_BITS    = 32;
	localparam int DEF_BLOCK_COUNT_BITS = 16;

	// Result queue geometry
	localparam int RES_DEPTH   = 4;
	localparam int RES_PTR_W   = $clog2(RES_DEPTH);
	localparam int RES_COUNT_W = $clog2(RES_DEPTH + 1);

	localparam int IN_TDATA_W  = 64;
	localparam int OUT_TDATA_W = 216;

	// ASCII codes of the characters the parser knows
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_NINE = 8'h39;
	localparam logic [7:0] CH_M    = 8'h4D;
	localparam logic [7:0] CH_I    = 8'h49;
	localparam logic [7:0] CH_D    = 8'h44;
	localparam logic [7:0] CH_N    = 8'h4E;
	localparam logic [7:0] CH_P    = 8'h50;
	localparam logic [7:0] CH_H    = 8'h48;
	localparam logic [7:0] CH_S    = 8'h53;

	typedef enum logic [1:0] {
		KIND_BLOCK   = 2'd0,
		KIND_SUMMARY = 2'd1,
		KIND_ERROR   = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		OP_M   = 3'd0,
		OP_I   = 3'd1,
		OP_D   = 3'd2,
		OP_N   = 3'd3,
		OP_P   = 3'd4,
		OP_PAD = 3'd5
	} op_t;

	typedef struct packed {
		kind_t       kind;
		op_t         op;
		logic [31:0] read_pos;
		logic [31:0] ref_pos;
		logic [31:0] length;
		logic [31:0] left_hard;
		logic [31:0] right_hard;
		logic [31:0] right_soft;
		logic [15:0] total;
		logic        last;
	} result_t;

	// Results produced by one character: count is 0, 1 or 2, r0 goes out first
	typedef struct packed {
		logic [1:0] count;
		result_t    r0;
		result_t    r1;
	} step_out_t;

endpackage

`default_nettype wire

FILE: rtl/cab_step.sv
// Parser state and per-character decode, accumulation and block generation.
`timescale 1ns / 1ps
`default_nettype none

module cab_step #(
	parameter int POSITION_BITS    = cab_pkg::DEF_POSITION_BITS,
	parameter int BLOCK_COUNT_BITS = cab_pkg::DEF_BLOCK_COUNT_BITS
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              fire,
	input  wire logic [7:0]        cigar_char,
	input  wire logic              end_of_string,
	input  wire logic [31:0]       record_ref_start,
	input  wire logic [19:0]       record_seq_length,
	output cab_pkg::step_out_t     res
);
	import cab_pkg::*;

	localparam int PW = POSITION_BITS;
	localparam int CW = BLOCK_COUNT_BITS;

	logic [31:0]   acc_q, acc_e, acc_n, acc_dig;
	logic [PW-1:0] rd_q, rd_e, rd_n;
	logic [PW-1:0] rf_q, rf_e, rf_n;
	logic [CW-1:0] cnt_q, cnt_e, cnt_n, cnt_fin;
	logic [31:0]   lhc_q, lhc_e, lhc_n;
	logic [31:0]   rhc_q, rhc_e, rhc_n;
	logic [31:0]   rsc_q, rsc_e, rsc_n;
	logic          nhn_q, nhn_e, nhn_n;
	logic          err_q, err_e, err_n;
	logic [19:0]   seq_q, seq_e;
	logic          inside_q;

	logic          start;
	logic          is_digit, is_blk, is_h, is_s, bad;
	logic          emit, pad;
	op_t           op_c;
	logic [35:0]   prod;
	logic [PW-1:0] len_p, pad_rd;

	always_comb begin
		start = !inside_q;
		acc_e = start ? '0 : acc_q;
		rd_e  = start ? '0 : rd_q;
		rf_e  = start ? PW'(record_ref_start - 32'd1) : rf_q;
		cnt_e = start ? '0 : cnt_q;
		lhc_e = start ? '0 : lhc_q;
		rhc_e = start ? '0 : rhc_q;
		rsc_e = start ? '0 : rsc_q;
		nhn_e = start ? 1'b0 : nhn_q;
		err_e = start ? 1'b0 : err_q;
		seq_e = start ? record_seq_length : seq_q;

		is_digit = (cigar_char >= CH_ZERO) && (cigar_char <= CH_NINE);
		prod = {1'b0, acc_e, 3'b000} + {3'b000, acc_e, 1'b0} + {32'd0, cigar_char[3:0]};
		acc_dig = (|prod[35:32]) ? '1 : prod[31:0];
		len_p = PW'(acc_e);

		is_blk = 1'b0;
		is_h   = 1'b0;
		is_s   = 1'b0;
		bad    = 1'b0;
		op_c   = OP_M;
		case (cigar_char)
			CH_M: begin is_blk = 1'b1; op_c = OP_M; end
			CH_I: begin is_blk = 1'b1; op_c = OP_I; end
			CH_D: begin is_blk = 1'b1; op_c = OP_D; end
			CH_N: begin is_blk = 1'b1; op_c = OP_N; end
			CH_P: begin is_blk = 1'b1; op_c = OP_P; end
			CH_H: is_h = 1'b1;
			CH_S: is_s = 1'b1;
			default: bad = 1'b1;
		endcase

		// hold by default
		acc_n = acc_e;
		rd_n  = rd_e;
		rf_n  = rf_e;
		cnt_n = cnt_e;
		lhc_n = lhc_e;
		rhc_n = rhc_e;
		rsc_n = rsc_e;
		nhn_n = nhn_e;
		err_n = err_e;
		emit  = 1'b0;

		if (err_e) begin
			err_n = 1'b1;
		end else if (is_digit) begin
			acc_n = acc_dig;
			err_n = end_of_string;
		end else begin
			acc_n = '0;
			nhn_n = is_s && (cnt_e != '0) && !end_of_string;
			err_n = (nhn_e && !is_h) || bad ||
				(is_h && !end_of_string && (cnt_e != '0));
			if (is_h && end_of_string)
				rhc_n = acc_e;
			if (is_h && !end_of_string && (cnt_e == '0))
				lhc_n = acc_e;
			if (is_s && (cnt_e != '0))
				rsc_n = acc_e;
			emit = is_blk && !err_n;
			if (is_h || is_s || (emit && (op_c == OP_M || op_c == OP_I)))
				rd_n = rd_e + len_p;
			if (emit && (op_c == OP_M || op_c == OP_D || op_c == OP_N))
				rf_n = rf_e + len_p;
			if (emit && (cnt_e != '1))
				cnt_n = cnt_e + 1'b1;
		end

		pad     = end_of_string && !err_n && (cnt_n == '0);
		cnt_fin = (pad && (cnt_n != '1)) ? cnt_n + 1'b1 : cnt_n;
		pad_rd  = PW'(seq_e) + PW'(lhc_n);

		res = '0;
		if (emit) begin
			res.r0.kind     = KIND_BLOCK;
			res.r0.op       = op_c;
			res.r0.read_pos = 32'(rd_e);
			res.r0.ref_pos  = 32'(rf_e);
			res.r0.length   = acc_e;
		end else if (pad) begin
			res.r0.kind     = KIND_BLOCK;
			res.r0.op       = OP_PAD;
			res.r0.read_pos = 32'(pad_rd);
			res.r0.ref_pos  = 32'(rf_n);
		end

		if (end_of_string && err_n) begin
			// an error drops anything this character produced
			res.count   = 2'd1;
			res.r0      = '0;
			res.r0.kind = KIND_ERROR;
			res.r0.op   = OP_M;
			res.r0.last = 1'b1;
		end else if (end_of_string) begin
			res.r1.kind       = KIND_SUMMARY;
			res.r1.op         = OP_M;
			res.r1.read_pos   = 32'(rd_n);
			res.r1.ref_pos    = 32'(rf_n);
			res.r1.left_hard  = lhc_n;
			res.r1.right_hard = rhc_n;
			res.r1.right_soft = rsc_n;
			res.r1.total      = 16'(cnt_fin);
			res.r1.last       = 1'b1;
			if (emit || pad) begin
				res.count = 2'd2;
			end else begin
				res.count = 2'd1;
				res.r0    = res.r1;
			end
		end else begin
			res.count = emit ? 2'd1 : 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			err_q    <= 1'b0;
			nhn_q    <= 1'b0;
			acc_q    <= '0;
			rd_q     <= '0;
			rf_q     <= '0;
			cnt_q    <= '0;
			lhc_q    <= '0;
			rhc_q    <= '0;
			rsc_q    <= '0;
			seq_q    <= '0;
		end else if (fire) begin
			// the next character after the end starts a fresh string
			inside_q <= !end_of_string;
			err_q    <= err_n;
			nhn_q    <= nhn_n;
			acc_q    <= acc_n;
			rd_q     <= rd_n;
			rf_q     <= rf_n;
			cnt_q    <= cnt_n;
			lhc_q    <= lhc_n;
			rhc_q    <= rhc_n;
			rsc_q    <= rsc_n;
			seq_q    <= seq_e;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cab_result_fifo.sv
// Small result queue that takes up to two results per cycle and hands out one.
`timescale 1ns / 1ps
`default_nettype none

module cab_result_fifo (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire cab_pkg::step_out_t push,
	input  wire logic               pop,
	output cab_pkg::result_t        head,
	output logic                    not_empty,
	output logic                    room
);
	import cab_pkg::*;

	result_t                mem [RES_DEPTH];
	logic [RES_PTR_W-1:0]   wp_q, rp_q, wp_next;
	logic [RES_COUNT_W-1:0] count_q;
	logic                   do_pop;

	assign wp_next   = wp_q + 1'b1;
	assign not_empty = (count_q != '0);
	assign do_pop    = pop && not_empty;
	assign head      = mem[rp_q];
	// two free slots needed, since one character may yield two results
	assign room      = (count_q <= RES_COUNT_W'(RES_DEPTH - 2));

	always_ff @(posedge clk) begin
		if (push.count != 2'd0)
			mem[wp_q] <= push.r0;
		if (push.count == 2'd2)
			mem[wp_next] <= push.r1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q    <= '0;
			rp_q    <= '0;
			count_q <= '0;
		end else begin
			wp_q    <= wp_q + RES_PTR_W'(push.count);
			if (do_pop)
				rp_q <= rp_q + 1'b1;
			count_q <= count_q + RES_COUNT_W'(push.count) - RES_COUNT_W'(do_pop);
		end
	end

endmodule

`default_nettype wire

FILE: rtl/cigar_to_alignment_blocks.sv
// Top level of the CIGAR string to alignment block converter.
//
// Channel  Dir  tdata (low bit first)                              tuser        tlast
// s_*      in   cigar_char[7:0], record_ref_start[31:0],           -            end_of_string
//               record_seq_length[19:0], 4 zero bits
// m_*      out  op_code[2:0], block_read_pos, block_ref_pos,       result_kind  last_of_run
//               block_length, left_hard_clip, right_hard_clip,
//               right_soft_clip (32 each), block_total[15:0], 5 zero bits
//
// While the result queue has room, one character per cycle enters an input register.
// A character that ends a string with a block or padding block yields two results,
// and the output, while m_tready is high, drains one result per cycle from a four-entry
// result queue. Input stalls only when that queue has fewer than two free entries.
// Reset is asynchronous and clears all control state; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module cigar_to_alignment_blocks #(
	parameter int POSITION_BITS    = cab_pkg::DEF_POSITION_BITS,
	parameter int BLOCK_COUNT_BITS = cab_pkg::DEF_BLOCK_COUNT_BITS
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            s_tvalid,
	output logic                                 s_tready,
	// cigar_char, record_ref_start, record_seq_length
	input  wire logic [cab_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  wire logic                            s_tlast,
	output logic                                 m_tvalid,
	input  wire logic                            m_tready,
	// op_code, block_read_pos, block_ref_pos, block_length, left_hard_clip,
	// right_hard_clip, right_soft_clip, block_total
	output logic [cab_pkg::OUT_TDATA_W-1:0]      m_tdata,
	// result_kind
	output logic [1:0]                           m_tuser,
	output logic                                 m_tlast
);
	import cab_pkg::*;

	logic        valid_s1;
	logic [7:0]  char_s1;
	logic        last_s1;
	logic [31:0] ref_start_s1;
	logic [19:0] seq_len_s1;

	logic        room, fire, s_take;
	step_out_t   step_res;
	result_t     head;

	assign fire     = valid_s1 && room;
	assign s_tready = !valid_s1 || room;
	assign s_take   = s_tvalid && s_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_take) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_take) begin
			char_s1      <= s_tdata[7:0];
			ref_start_s1 <= s_tdata[39:8];
			seq_len_s1   <= s_tdata[59:40];
			last_s1      <= s_tlast;
		end
	end

	cab_step #(
		.POSITION_BITS    (POSITION_BITS),
		.BLOCK_COUNT_BITS (BLOCK_COUNT_BITS)
	) u_step (
		.clk               (clk),
		.arst_n            (arst_n),
		.fire              (fire),
		.cigar_char        (char_s1),
		.end_of_string     (last_s1),
		.record_ref_start  (ref_start_s1),
		.record_seq_length (seq_len_s1),
		.res               (step_res)
	);

	step_out_t push;
	always_comb begin
		push = step_res;
		// drop results of a character that is not being consumed
		if (!fire)
			push.count = 2'd0;
	end

	cab_result_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.pop       (m_tready),
		.head      (head),
		.not_empty (m_tvalid),
		.room      (room)
	);

	assign m_tdata = {5'b00000, head.total, head.right_soft, head.right_hard,
		head.left_hard, head.length, head.ref_pos, head.read_pos, head.op};
	assign m_tuser = head.kind;
	assign m_tlast = head.last;

endmodule

`default_nettype wire

FILE: test/cigar_to_alignment_blocks_tb.sv
// Self-checking testbench for the CIGAR to alignment block converter.
`timescale 1ns / 1ps

module cigar_to_alignment_blocks_tb;
	import cab_pkg::*;

	localparam int          RANDOM_ITEMS = 1150;
	localparam int          N_CASES      = 7;
	localparam logic [7:0]  OP_CHARS [5] = '{CH_M, CH_I, CH_D, CH_N, CH_P};

	// How a directed row is checked: by the parser model, as an error, or as silent
	typedef enum logic [1:0] {
		CHK_PREDICT,
		CHK_NONE,
		CHK_ERROR
	} row_chk_t;

	typedef struct {
		string       text;
		logic [31:0] ref_start;
		logic [19:0] seq_len;
		bit          ends_bad;
	} cigar_case_t;

	logic clk = 1'b0;
	logic arst_n;
	logic s_tvalid;
	logic s_tready;
	// cigar_char, record_ref_start, record_seq_length
	logic [IN_TDATA_W-1:0] s_tdata;
	logic s_tlast;
	logic m_tvalid;
	logic m_tready;
	// op_code, block_read_pos, block_ref_pos, block_length, left_hard_clip,
	// right_hard_clip, right_soft_clip, block_total
	logic [OUT_TDATA_W-1:0] m_tdata;
	// result_kind
	logic [1:0] m_tuser;
	logic m_tlast;

	// Parser model state
	logic [31:0] acc_len;
	logic [31:0] rd_pos;
	logic [31:0] rf_pos;
	logic [15:0] nblocks;
	logic [31:0] lclip;
	logic [31:0] rhclip;
	logic [31:0] rsclip;
	logic        want_hard;
	logic        bad_str;
	logic        in_str;
	logic [19:0] seq_hold;

	result_t     step_results[$];
	result_t     awaited_results[$];
	logic [7:0]  cigar_text[$];
	cigar_case_t directed_cases [N_CASES];

	int items_sent;
	int strings_sent;
	int results_seen;
	int blocks_seen_out;
	int summaries_seen;
	int errors_seen_out;
	int mismatches;

	cigar_to_alignment_blocks i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	function automatic result_t mk_res(kind_t k, op_t o, logic [31:0] rd, logic [31:0] rf,
			logic [31:0] ln, logic [31:0] lh, logic [31:0] rh, logic [31:0] rs,
			logic [15:0] tot, logic lst);
		result_t r;
		r.kind       = k;
		r.op         = o;
		r.read_pos   = rd;
		r.ref_pos    = rf;
		r.length     = ln;
		r.left_hard  = lh;
		r.right_hard = rh;
		r.right_soft = rs;
		r.total      = tot;
		r.last       = lst;
		return r;
	endfunction

	function automatic string fmt_res(result_t r);
		return $sformatf("kind=%0d op=%0d rd=%h rf=%h len=%h lh=%h rh=%h rs=%h tot=%0d last=%0d",
			r.kind, r.op, r.read_pos, r.ref_pos, r.length, r.left_hard, r.right_hard,
			r.right_soft, r.total, r.last);
	endfunction

	function automatic void clear_parser();
		acc_len   = '0;
		rd_pos    = '0;
		rf_pos    = '0;
		nblocks   = '0;
		lclip     = '0;
		rhclip    = '0;
		rsclip    = '0;
		want_hard = 1'b0;
		bad_str   = 1'b0;
		in_str    = 1'b0;
		seq_hold  = '0;
	endfunction

	function automatic void bump_blocks();
		if (nblocks != 16'hFFFF)
			nblocks++;
	endfunction

	// Advance the parser model by one character; the results land in step_results
	function automatic void parse_cigar_char(logic [7:0] ch, logic fin, logic [31:0] ref_start,
			logic [19:0] seq_len);
		logic [63:0] v;
		logic [31:0] len;
		bit          is_op;
		op_t         op;
		step_results.delete();
		is_op = 1'b0;
		op    = OP_M;
		if (!in_str) begin
			clear_parser();
			in_str   = 1'b1;
			rf_pos   = ref_start - 32'd1;
			seq_hold = seq_len;
		end
		if (!bad_str) begin
			if (ch >= CH_ZERO && ch <= CH_NINE) begin
				v = 64'(acc_len) * 64'd10 + 64'(ch - CH_ZERO);
				acc_len = (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
				if (fin)
					bad_str = 1'b1;
			end else begin
				len     = acc_len;
				acc_len = '0;
				// a soft clip after a block must be followed by the closing hard clip
				if (want_hard && ch != CH_H)
					bad_str = 1'b1;
				want_hard = 1'b0;
				case (ch)
					CH_M: begin is_op = 1'b1; op = OP_M; end
					CH_I: begin is_op = 1'b1; op = OP_I; end
					CH_D: begin is_op = 1'b1; op = OP_D; end
					CH_N: begin is_op = 1'b1; op = OP_N; end
					CH_P: begin is_op = 1'b1; op = OP_P; end
					CH_H: begin
						if (fin)
							rhclip = len;
						else if (nblocks == 0)
							lclip = len;
						else
							bad_str = 1'b1;
						rd_pos += len;
					end
					CH_S: begin
						if (nblocks != 0) begin
							rsclip = len;
							if (!fin)
								want_hard = 1'b1;
						end
						rd_pos += len;
					end
					default: bad_str = 1'b1;
				endcase
				if (is_op && !bad_str) begin
					step_results.insert(step_results.size(), mk_res(KIND_BLOCK, op, rd_pos,
						rf_pos, len, '0, '0, '0, '0, 1'b0));
					if (op == OP_M || op == OP_I)
						rd_pos += len;
					if (op == OP_M || op == OP_D || op == OP_N)
						rf_pos += len;
					bump_blocks();
				end
			end
		end
		if (fin) begin
			if (bad_str) begin
				step_results.delete();
				step_results.insert(step_results.size(), mk_res(KIND_ERROR, OP_M, '0, '0,
					'0, '0, '0, '0, '0, 1'b1));
			end else begin
				if (nblocks == 0) begin
					step_results.insert(step_results.size(), mk_res(KIND_BLOCK, OP_PAD,
						32'(seq_hold) + lclip, rf_pos, '0, '0, '0, '0, '0, 1'b0));
					bump_blocks();
				end
				step_results.insert(step_results.size(), mk_res(KIND_SUMMARY, OP_M, rd_pos,
					rf_pos, '0, lclip, rhclip, rsclip, nblocks, 1'b1));
			end
			clear_parser();
		end
	endfunction

	task automatic send_char(logic [7:0] ch, logic fin, logic [31:0] ref_start,
			logic [19:0] seq_len, row_chk_t chk);
		@(negedge clk);
		s_tvalid = 1'b1;
		s_tlast  = fin;
		s_tdata  = {4'b0, seq_len, ref_start, ch};
		do
			@(posedge clk);
		while (!s_tready);
		parse_cigar_char(ch, fin, ref_start, seq_len);
		case (chk)
			CHK_PREDICT: foreach (step_results[i])
				awaited_results.insert(awaited_results.size(), step_results[i]);
			CHK_ERROR: awaited_results.insert(awaited_results.size(), mk_res(KIND_ERROR,
				OP_M, '0, '0, '0, '0, '0, '0, '0, 1'b1));
			default: ;
		endcase
		items_sent++;
		if (fin)
			strings_sent++;
	endtask

	task automatic idle_input(int cycles);
		repeat (cycles) begin
			@(negedge clk);
			s_tvalid = 1'b0;
			s_tlast  = 1'($urandom_range(0, 1));
			s_tdata  = {4'b0, 20'($urandom), 32'($urandom), 8'($urandom)};
		end
	endtask

	task automatic append_run_length();
		string big;
		case ($urandom_range(0, 19))
			0, 1, 2, 3: ;  // no digits: length zero
			4: begin
				big = $urandom_range(0, 1) ? "4294967295" : "4294967296";
				for (int i = 0; i < big.len(); i++)
					cigar_text.insert(cigar_text.size(), big[i]);
			end
			5, 6: repeat ($urandom_range(9, 12))
				cigar_text.insert(cigar_text.size(), CH_ZERO + 8'($urandom_range(0, 9)));
			7: begin
				repeat ($urandom_range(1, 2))
					cigar_text.insert(cigar_text.size(), CH_ZERO);
				cigar_text.insert(cigar_text.size(), CH_ZERO + 8'($urandom_range(1, 9)));
			end
			default: repeat ($urandom_range(1, 3))
				cigar_text.insert(cigar_text.size(), CH_ZERO + 8'($urandom_range(0, 9)));
		endcase
	endtask

	// Build one random string: mostly well formed, some damaged or pure noise
	task automatic make_cigar();
		int nops;
		int pos;
		cigar_text.delete();
		if ($urandom_range(0, 19) == 0) begin
			repeat ($urandom_range(1, 6))
				cigar_text.insert(cigar_text.size(), 8'($urandom_range(0, 255)));
			return;
		end
		if ($urandom_range(0, 3) == 0) begin
			append_run_length();
			cigar_text.insert(cigar_text.size(), CH_H);
		end
		if ($urandom_range(0, 4) == 0) begin
			append_run_length();
			cigar_text.insert(cigar_text.size(), CH_S);
		end
		nops = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 6);
		repeat (nops) begin
			append_run_length();
			cigar_text.insert(cigar_text.size(), OP_CHARS[$urandom_range(0, 4)]);
		end
		if ($urandom_range(0, 2) == 0) begin
			append_run_length();
			cigar_text.insert(cigar_text.size(), CH_S);
		end
		if ($urandom_range(0, 2) == 0) begin
			append_run_length();
			cigar_text.insert(cigar_text.size(), CH_H);
		end
		if (cigar_text.size() == 0)
			cigar_text.insert(cigar_text.size(), CH_H);
		if ($urandom_range(0, 5) == 0) begin
			pos = $urandom_range(0, cigar_text.size() - 1);
			case ($urandom_range(0, 4))
				0: cigar_text[pos] = 8'($urandom_range(0, 255));
				1: cigar_text.insert(cigar_text.size(), CH_ZERO + 8'($urandom_range(0, 9)));
				2: cigar_text.insert(pos, CH_H);
				3: cigar_text.insert(pos, CH_S);
				default: cigar_text.insert(pos, 8'($urandom_range(0, 255)));
			endcase
		end
	endtask

	task automatic check_result();
		result_t got;
		result_t want;
		got.kind       = kind_t'(m_tuser);
		got.op         = op_t'(m_tdata[2:0]);
		got.read_pos   = m_tdata[34:3];
		got.ref_pos    = m_tdata[66:35];
		got.length     = m_tdata[98:67];
		got.left_hard  = m_tdata[130:99];
		got.right_hard = m_tdata[162:131];
		got.right_soft = m_tdata[194:163];
		got.total      = m_tdata[210:195];
		got.last       = m_tlast;
		results_seen++;
		if (got.kind == KIND_BLOCK)
			blocks_seen_out++;
		else if (got.kind == KIND_SUMMARY)
			summaries_seen++;
		else if (got.kind == KIND_ERROR)
			errors_seen_out++;
		if (awaited_results.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("unexpected result %0d: %s", results_seen, fmt_res(got));
		end else begin
			want = awaited_results.pop_front();
			if (got.kind !== want.kind || got.op !== want.op
					|| got.read_pos !== want.read_pos || got.ref_pos !== want.ref_pos
					|| got.length !== want.length || got.left_hard !== want.left_hard
					|| got.right_hard !== want.right_hard
					|| got.right_soft !== want.right_soft
					|| got.total !== want.total || got.last !== want.last) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("mismatch at result %0d", results_seen);
					$display("  expected %s", fmt_res(want));
					$display("  actual   %s", fmt_res(got));
				end
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready)
			check_result();
	end

	// Receiver: changing ready patterns plus one long hold to back up the input
	initial begin : receiver
		int unsigned cyc;
		int unsigned mode;
		bit held;
		cyc  = 0;
		mode = 0;
		held = 1'b0;
		m_tready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(negedge clk);
			if (!held && results_seen >= 40) begin
				held = 1'b1;
				m_tready = 1'b0;
				repeat (300) @(negedge clk);
			end
			if (cyc % 64 == 0)
				mode = $urandom_range(0, 3);
			case (mode)
				0: m_tready = 1'b1;
				1: m_tready = 1'($urandom_range(0, 1));
				2: m_tready = (cyc % 5) != 0;
				default: m_tready = ($urandom_range(0, 4) == 0);
			endcase
			cyc++;
		end
	end

	initial begin : stimulus
		cigar_case_t cs;
		int burst_left;
		int gap;
		int n_directed;
		bit drained;
		row_chk_t chk;
		logic fin;
		burst_left = 0;
		drained    = 1'b0;
		items_sent = 0;
		strings_sent = 0;
		results_seen = 0;
		blocks_seen_out = 0;
		summaries_seen = 0;
		errors_seen_out = 0;
		mismatches = 0;
		clear_parser();
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tlast  = 1'b0;
		s_tdata  = '0;

		directed_cases[0] = '{"0M", 32'd0, 20'd0, 1'b0};
		directed_cases[1] = '{"H", 32'hFFFF_FFFF, 20'hF_FFFF, 1'b0};
		directed_cases[2] = '{" ", 32'd1, 20'd1, 1'b1};
		directed_cases[3] = '{"7", 32'd5, 20'd9, 1'b1};
		directed_cases[4] = '{"MHM", 32'd20, 20'd4, 1'b1};
		directed_cases[5] = '{"MSM", 32'd30, 20'd4, 1'b1};
		directed_cases[6] = '{"2H1S5M3IDNP2S3H", 32'd100, 20'd30, 1'b0};

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed strings, back to back
		for (int c = 0; c < N_CASES; c++) begin
			cs = directed_cases[c];
			for (int i = 0; i < cs.text.len(); i++) begin
				fin = (i == cs.text.len() - 1);
				if (cs.ends_bad && fin)
					chk = CHK_ERROR;
				else if (cs.ends_bad && cs.text[i] >= CH_ZERO && cs.text[i] <= CH_NINE)
					chk = CHK_NONE;
				else
					chk = CHK_PREDICT;
				send_char(cs.text[i], fin, cs.ref_start, cs.seq_len, chk);
			end
		end
		n_directed = items_sent;

		// Random strings in bursts
		while (items_sent < n_directed + RANDOM_ITEMS) begin
			make_cigar();
			foreach (cigar_text[i]) begin
				if (burst_left == 0) begin
					gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					idle_input(gap);
					burst_left = $urandom_range(1, 40);
				end
				burst_left--;
				send_char(cigar_text[i], i == cigar_text.size() - 1, 32'($urandom),
					20'($urandom), CHK_PREDICT);
			end
			// hold the input once until the output has fully drained
			if (!drained && items_sent >= n_directed + RANDOM_ITEMS / 2) begin
				drained = 1'b1;
				idle_input(1);
				wait (awaited_results.size() == 0);
			end
		end
		idle_input(1);

		wait (awaited_results.size() == 0);
		repeat (20) @(posedge clk);
		$display("sent %0d characters in %0d strings (%0d directed characters)",
			items_sent, strings_sent, n_directed);
		$display("checked %0d results: %0d blocks, %0d summaries, %0d errors; %0d mismatches",
			results_seen, blocks_seen_out, summaries_seen, errors_seen_out, mismatches);
		if (mismatches == 0)
			$display("status: pass");
		else
			$display("status: fail");
		$finish;
	end

	initial begin : watchdog
		#2_000_000;
		$display("timeout with %0d results still awaited", awaited_results.size());
		$display("status: fail");
		$finish;
	end

endmodule
